// File: hw/rtl/rig_pkg.sv
// Shared types and constants for the group-reversal block.
`default_nettype none

package rig_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned GSIZE_W = 5;
  // Wide enough for any count up to the largest supported group depth.
  localparam int unsigned CNT_W   = 7;

  localparam logic [GSIZE_W-1:0] GROUP_SIZE_RESET = 5'd1;

  // Register index, taken from paddr[2].
  localparam logic REG_GROUP_SIZE = 1'b0;

  typedef struct packed {
    logic store;  // write the incoming item into the buffer
    logic start;  // begin a burst with the buffered items
    logic rd;     // read one buffered item into the output register
  } cmd_t;

  typedef struct packed {
    logic hit;    // the incoming item completes a group
    logic more;   // items of the current burst are still to be read
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/rig_if.sv
// Stream interfaces for list items in and reordered items out.
`default_nettype none

interface rig_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        end_of_list;

  modport source (output valid, output value, output end_of_list, input ready);
  modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

interface rig_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_value;
  logic        burst_end;
  logic        list_end;

  modport source (output valid, output out_value, output burst_end, output list_end,
                  input ready);
  modport sink   (input valid, input out_value, input burst_end, input list_end,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rig_ctrl.sv
// Controller state machine: accepts items and sequences buffer reads and output.
`default_nettype none

module rig_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            end_of_list_i,
  input  wire logic            out_ready_i,
  input  wire rig_pkg::status_t status_i,
  output rig_pkg::cmd_t        cmd_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);
  import rig_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.store = in_valid_i && in_ready_q;
    cmd_o.start = cmd_o.store && (status_i.hit || end_of_list_i);
    cmd_o.rd    = (state_q == ST_READ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            state_q    <= ST_READ;
            in_ready_q <= 1'b0;
          end
        end
        ST_READ: begin
          state_q     <= ST_SHOW;
          out_valid_q <= 1'b1;
        end
        ST_SHOW: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (status_i.more) begin
              state_q <= ST_READ;
            end else begin
              state_q    <= ST_IDLE;
              in_ready_q <= 1'b1;
            end
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/rig_datapath.sv
// Datapath: group buffer, fill and burst counters, output register.
`default_nettype none

module rig_datapath #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rig_pkg::cmd_t                  cmd_i,
  output rig_pkg::status_t                    status_o,
  input  wire logic [rig_pkg::VALUE_W-1:0]    value_i,
  input  wire logic                           end_of_list_i,
  input  wire logic [rig_pkg::GSIZE_W-1:0]    group_size_i,
  output logic      [rig_pkg::VALUE_W-1:0]    out_value_o,
  output logic                                burst_end_o,
  output logic                                list_end_o
);
  import rig_pkg::*;

  localparam int unsigned FW = $clog2(MAX_GROUP + 1);
  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_GROUP);

  logic [VALUE_W-1:0] mem_q [MAX_GROUP];
  logic [FW-1:0]      fill_q;
  logic [CNT_W-1:0]   remain_q;
  logic [AW-1:0]      idx_q;
  logic               rev_q;
  logic               last_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               burst_end_q;
  logic               list_end_q;

  logic [CNT_W-1:0]   gsize_ext;
  logic [CNT_W-1:0]   k_eff;
  logic [CNT_W-1:0]   fill_next;
  logic               hit;
  logic               final_rd;

  // A size of zero acts as one; sizes beyond the buffer depth saturate.
  always_comb begin
    gsize_ext = CNT_W'(group_size_i);
    if (gsize_ext == '0) begin
      k_eff = CNT_W'(1);
    end else if (gsize_ext > MaxCnt) begin
      k_eff = MaxCnt;
    end else begin
      k_eff = gsize_ext;
    end
    fill_next = CNT_W'(fill_q) + CNT_W'(1);
    hit       = (fill_next >= k_eff);
    final_rd  = (remain_q == CNT_W'(1));
  end

  assign status_o.hit  = hit;
  assign status_o.more = (remain_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[fill_q[AW-1:0]] <= value_i;
    end
    if (cmd_i.rd) begin
      out_value_q <= mem_q[idx_q];
      burst_end_q <= final_rd;
      list_end_q  <= final_rd && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      remain_q <= '0;
      idx_q    <= '0;
      rev_q    <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        if (cmd_i.start) begin
          // A full group is read back from the newest entry downward,
          // a short tail at the end of the list from the oldest upward.
          fill_q   <= '0;
          remain_q <= fill_next;
          idx_q    <= hit ? fill_q[AW-1:0] : '0;
          rev_q    <= hit;
          last_q   <= end_of_list_i;
        end else begin
          fill_q <= fill_next[FW-1:0];
        end
      end
      if (cmd_i.rd) begin
        remain_q <= remain_q - CNT_W'(1);
        idx_q    <= rev_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
      end
    end
  end

  assign out_value_o = out_value_q;
  assign burst_end_o = burst_end_q;
  assign list_end_o  = list_end_q;

endmodule

`default_nettype wire

// File: hw/rtl/reverse_in_groups_of_k_unit.sv
// An item that completes a group or ends the list starts a burst: each result is first
// read from the buffer (ST_READ), then held in the output register (ST_SHOW) until the
// sink takes it, and the next read follows while items of the burst remain.
// Items that only fill the buffer are taken one per cycle; no item is taken during
// a burst, as the single buffer read port and output register serve the burst.
// Reset is asynchronous and active low: empty buffer, group size one, no pending output.
`default_nettype none

module reverse_in_groups_of_k_unit #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  rig_in_if.sink           in_i,
  rig_out_if.source        out_o
);
  import rig_pkg::*;

  logic [GSIZE_W-1:0] group_size_q;
  cmd_t               cmd;
  status_t            status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_GROUP_SIZE)) begin
      group_size_q <= pwdata[GSIZE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GROUP_SIZE) ? 32'(group_size_q) : '0;

  rig_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .end_of_list_i (in_i.end_of_list),
    .out_ready_i   (out_o.ready),
    .status_i      (status),
    .cmd_o         (cmd),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (out_o.valid)
  );

  rig_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_i       (in_i.value),
    .end_of_list_i (in_i.end_of_list),
    .group_size_i  (group_size_q),
    .out_value_o   (out_o.out_value),
    .burst_end_o   (out_o.burst_end),
    .list_end_o    (out_o.list_end)
  );

endmodule

`default_nettype wire

// File: hw/rtl/rig_checker.sv
// Port-level checks for the group-reversal block, bound to the top level.
`default_nettype none

module rig_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_eol_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_value_i,
  input wire logic        burst_end_i,
  input wire logic        list_end_i
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("result changed while stalled");

  // The final element of the list always closes its burst.
  a_list_end_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && list_end_i |-> burst_end_i)
    else $error("list_end without burst_end");

  // Items are not taken while a burst is being delivered.
  a_no_accept_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready during a burst");

  // The end of a list always starts a burst.
  a_eol_starts_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_eol_i |=> !in_ready_i)
    else $error("end of list did not start a burst");

endmodule

bind reverse_in_groups_of_k_unit rig_checker u_rig_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_eol_i    (in_i.end_of_list),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.out_value),
  .burst_end_i (out_o.burst_end),
  .list_end_i  (out_o.list_end)
);

`default_nettype wire
